// ===== design/adam_pkg.sv =====
package adam_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] IDX_LEARN_RATE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] IDX_BETA_ONE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] IDX_BETA_TWO = 3'd2;
	localparam logic [CFG_IDX_W-1:0] IDX_EPS_TERM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] IDX_DECAY_RATE = 3'd4;

	localparam logic [15:0] RST_LEARN_RATE = 16'd66;
	localparam logic [15:0] RST_BETA_ONE = 16'd58982;
	localparam logic [15:0] RST_BETA_TWO = 16'd65470;
	localparam logic [15:0] RST_EPS_TERM = 16'd1;
	localparam logic [15:0] RST_DECAY_RATE = 16'd0;
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_P1 = 4'd1;
	localparam logic [3:0] OP_P2 = 4'd2;
	localparam logic [3:0] OP_DEC = 4'd3;
	localparam logic [3:0] OP_M1A = 4'd4;
	localparam logic [3:0] OP_M1B = 4'd5;
	localparam logic [3:0] OP_T1 = 4'd6;
	localparam logic [3:0] OP_U = 4'd7;
	localparam logic [3:0] OP_T2 = 4'd8;
	localparam logic [3:0] OP_MH = 4'd9;
	localparam logic [3:0] OP_VH = 4'd10;
	localparam logic [3:0] OP_RT = 4'd11;
	localparam logic [3:0] OP_NUM = 4'd12;
	localparam logic [3:0] OP_Q = 4'd13;

	localparam logic [6:0] MUL_STEPS = 7'd4;
	localparam logic [6:0] DIV_STEPS = 7'd64;
	localparam logic [6:0] SQRT_STEPS = 7'd32;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic load;
		logic start;
		logic emit;
		logic [3:0] op;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic first;
		logic decay_nz;
		logic corr_ok;
	} status_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] x);
		return x[63] ? 64'd0 - 64'(x) : 64'(x);
	endfunction

	function automatic logic signed [63:0] smake64(input logic neg, input logic [63:0] m);
		logic signed [63:0] mm;
		mm = (m > 64'(S64_MAX)) ? S64_MAX : signed'(m);
		return neg ? -mm : mm;
	endfunction

	function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return signed'(s[63:0]);
	endfunction

endpackage

// ===== design/adam_in_if.sv =====
interface adam_in_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic signed [W-1:0] weight_in;
	logic signed [W-1:0] grad_in;
	logic signed [W-1:0] moment_one_in;
	logic [W-1:0] moment_two_in;
	logic first_of_step;

	modport source(output valid, weight_in, grad_in, moment_one_in, moment_two_in,
		first_of_step, input ready);
	modport sink(input valid, weight_in, grad_in, moment_one_in, moment_two_in,
		first_of_step, output ready);
endinterface

// ===== design/adam_out_if.sv =====
interface adam_out_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic signed [W-1:0] weight_out;
	logic signed [W-1:0] moment_one_out;
	logic [W-1:0] moment_two_out;

	modport source(output valid, weight_out, moment_one_out, moment_two_out, input ready);
	modport sink(input valid, weight_out, moment_one_out, moment_two_out, output ready);
endinterface

// ===== design/adam_ctrl.sv =====
module adam_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input adam_pkg::status_t status,
	output adam_pkg::cmd_t cmd
);
	import adam_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_ISSUE = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_FIN = 3'd4;

	logic [2:0] state_q;
	logic [3:0] op_q;
	logic out_valid_q;
	logic emit;

	function automatic logic [3:0] next_op(input logic [3:0] op, input status_t st);
		case (op)
			OP_P1: return OP_P2;
			OP_P2: return st.decay_nz ? OP_DEC : OP_M1A;
			OP_DEC: return OP_M1A;
			OP_M1A: return OP_M1B;
			OP_M1B: return OP_T1;
			OP_T1: return OP_U;
			OP_U: return OP_T2;
			OP_T2: return st.corr_ok ? OP_MH : OP_NONE;
			OP_MH: return OP_VH;
			OP_VH: return OP_RT;
			OP_RT: return OP_NUM;
			OP_NUM: return OP_Q;
			default: return OP_NONE;
		endcase
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign emit = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.load = in_valid && in_ready;
		cmd.start = (state_q == ST_ISSUE);
		cmd.emit = emit;
		cmd.op = op_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					op_q <= status.first ? OP_P1 : (status.decay_nz ? OP_DEC : OP_M1A);
					state_q <= ST_ISSUE;
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (status.done) begin
						op_q <= next_op(op_q, status);
						state_q <= (next_op(op_q, status) == OP_NONE) ? ST_FIN : ST_ISSUE;
					end
				end
				ST_FIN: begin
					if (emit)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== design/adam_dp.sv =====
module adam_dp #(
	parameter int VALUE_WIDTH = adam_pkg::VALUE_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input adam_pkg::cmd_t cmd,
	output adam_pkg::status_t status,
	input logic cfg_we,
	input logic [adam_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [adam_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic signed [VALUE_WIDTH-1:0] weight_in,
	input logic signed [VALUE_WIDTH-1:0] grad_in,
	input logic signed [VALUE_WIDTH-1:0] moment_one_in,
	input logic [VALUE_WIDTH-1:0] moment_two_in,
	input logic first_of_step,
	output logic signed [VALUE_WIDTH-1:0] weight_out,
	output logic signed [VALUE_WIDTH-1:0] moment_one_out,
	output logic [VALUE_WIDTH-1:0] moment_two_out
);
	import adam_pkg::*;

	localparam logic signed [63:0] SMAX_W = signed'(64'((65'd1 << (VALUE_WIDTH - 1)) - 65'd1));
	localparam logic signed [63:0] SMIN_W = -SMAX_W - 64'sd1;
	localparam logic [63:0] UMAX_W = {64{1'b1}} >> (64 - VALUE_WIDTH);

	function automatic logic signed [63:0] clamp_w(input logic signed [63:0] x);
		if (x > SMAX_W)
			return SMAX_W;
		if (x < SMIN_W)
			return SMIN_W;
		return x;
	endfunction

	logic [15:0] lr_q, b1_q, b2_q, eps_q, dec_q;
	logic [16:0] p1_q, p2_q;
	logic signed [63:0] w_q, g_q, m1_q, m1n_q, wn_q;
	logic [63:0] v_q, ta_q, tb_q, m2n_q, mh_q, vh_q, root_q, num_q;
	logic first_q;

	logic [3:0] cur_op_q;
	logic run_q, done_q;
	logic [6:0] cnt_q;
	logic [127:0] acc_q;
	logic [63:0] ma_q, mb_q;
	logic [63:0] dn_q, dd_q, rem_q;
	logic [63:0] sx_q, sr_q, sb_q;

	logic [16:0] d1, d2;
	logic [63:0] m1n_mag, rsh, rfull, den;
	logic [6:0] lim;
	logic is_mul, is_div;
	logic [63:0] op_a, op_b, div_n, div_d, sq_x;
	logic [64:0] dtmp, ssum, m2sum;
	logic dge, sge;
	logic [63:0] m2sat;
	logic [79:0] pprod;

	assign d1 = ONE_Q16 - p1_q;
	assign d2 = ONE_Q16 - p2_q;
	assign m1n_mag = mag64(m1n_q);
	assign rsh = (acc_q[127:80] != 48'd0) ? {64{1'b1}} : acc_q[79:16];
	assign rfull = (acc_q[127:64] != 64'd0) ? {64{1'b1}} : acc_q[63:0];
	assign den = root_q + 64'(eps_q);
	assign pprod = ma_q * mb_q[63:48];

	always_comb begin
		status.done = done_q;
		status.first = first_q;
		status.decay_nz = (dec_q != 16'd0);
		status.corr_ok = (d1 != 17'd0) && (d2 != 17'd0);
	end

	always_comb begin
		is_mul = 1'b0;
		is_div = 1'b0;
		op_a = 64'd0;
		op_b = 64'd0;
		div_n = 64'd0;
		div_d = 64'd0;
		case (cmd.op)
			OP_P1: begin is_mul = 1'b1; op_a = 64'(p1_q); op_b = 64'(b1_q); end
			OP_P2: begin is_mul = 1'b1; op_a = 64'(p2_q); op_b = 64'(b2_q); end
			OP_DEC: begin is_mul = 1'b1; op_a = mag64(w_q); op_b = 64'(dec_q); end
			OP_M1A: begin is_mul = 1'b1; op_a = mag64(m1_q); op_b = 64'(b1_q); end
			OP_M1B: begin
				is_mul = 1'b1;
				op_a = mag64(g_q);
				op_b = 64'(ONE_Q16 - {1'b0, b1_q});
			end
			OP_T1: begin is_mul = 1'b1; op_a = v_q; op_b = 64'(b2_q); end
			OP_U: begin
				is_mul = 1'b1;
				op_a = mag64(g_q);
				op_b = 64'(ONE_Q16 - {1'b0, b2_q});
			end
			OP_T2: begin is_mul = 1'b1; op_a = mag64(g_q); op_b = tb_q; end
			OP_NUM: begin is_mul = 1'b1; op_a = mh_q; op_b = 64'(lr_q); end
			OP_MH: begin is_div = 1'b1; div_n = {m1n_mag[47:0], 16'd0}; div_d = 64'(d1); end
			OP_VH: begin is_div = 1'b1; div_n = {m2n_q[47:0], 16'd0}; div_d = 64'(d2); end
			OP_Q: begin is_div = 1'b1; div_n = num_q; div_d = den; end
			default: ;
		endcase
	end

	assign sq_x = (vh_q[63:48] != 16'd0) ? vh_q : {vh_q[47:0], 16'd0};

	always_comb begin
		case (cur_op_q)
			OP_MH, OP_VH, OP_Q: lim = DIV_STEPS;
			OP_RT: lim = SQRT_STEPS;
			default: lim = MUL_STEPS;
		endcase
	end

	assign dtmp = {rem_q, dn_q[63]};
	assign dge = dtmp >= {1'b0, dd_q};
	assign ssum = {1'b0, sr_q} + {1'b0, sb_q};
	assign sge = {1'b0, sx_q} >= ssum;
	assign m2sum = {1'b0, ta_q} + {1'b0, rsh};
	assign m2sat = m2sum[64] ? {64{1'b1}} : m2sum[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= RST_LEARN_RATE;
			b1_q <= RST_BETA_ONE;
			b2_q <= RST_BETA_TWO;
			eps_q <= RST_EPS_TERM;
			dec_q <= RST_DECAY_RATE;
			p1_q <= ONE_Q16;
			p2_q <= ONE_Q16;
			run_q <= 1'b0;
			done_q <= 1'b0;
			cur_op_q <= OP_NONE;
			cnt_q <= 7'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					IDX_LEARN_RATE: lr_q <= cfg_data;
					IDX_BETA_ONE: b1_q <= cfg_data;
					IDX_BETA_TWO: b2_q <= cfg_data;
					IDX_EPS_TERM: eps_q <= cfg_data;
					IDX_DECAY_RATE: dec_q <= cfg_data;
					default: ;
				endcase
			end
			done_q <= 1'b0;
			if (cmd.start) begin
				cur_op_q <= cmd.op;
				cnt_q <= 7'd0;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == lim - 7'd1) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
			if (done_q && (cur_op_q == OP_P1))
				p1_q <= rsh[16:0];
			if (done_q && (cur_op_q == OP_P2))
				p2_q <= rsh[16:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q <= 64'(weight_in);
			g_q <= 64'(grad_in);
			m1_q <= 64'(moment_one_in);
			v_q <= 64'(moment_two_in);
			first_q <= first_of_step;
		end
		if (cmd.start) begin
			ma_q <= op_a;
			mb_q <= op_b;
			acc_q <= 128'd0;
			dn_q <= div_n;
			dd_q <= div_d;
			rem_q <= 64'd0;
			sx_q <= sq_x;
			sr_q <= 64'd0;
			sb_q <= 64'd1 << 62;
			if (!is_mul && !is_div)
				sb_q <= 64'd1 << 62;
		end else if (run_q) begin
			acc_q <= (acc_q << 16) + 128'(pprod);
			mb_q <= mb_q << 16;
			rem_q <= dge ? 64'(dtmp - {1'b0, dd_q}) : dtmp[63:0];
			dn_q <= {dn_q[62:0], dge};
			sx_q <= sge ? sx_q - ssum[63:0] : sx_q;
			sr_q <= sge ? (sr_q >> 1) + sb_q : sr_q >> 1;
			sb_q <= sb_q >> 2;
		end
		if (done_q) begin
			case (cur_op_q)
				OP_DEC: g_q <= clamp_w(add_sat64(g_q, smake64(w_q[63], rsh)));
				OP_M1A: ta_q <= rsh;
				OP_M1B: m1n_q <= clamp_w(add_sat64(smake64(m1_q[63], ta_q),
					smake64(g_q[63], rsh)));
				OP_T1: ta_q <= rsh;
				OP_U: tb_q <= rsh;
				OP_T2: m2n_q <= (m2sat > UMAX_W) ? UMAX_W : m2sat;
				OP_MH: mh_q <= (m1n_mag[63:48] != 16'd0) ? {64{1'b1}} : dn_q;
				OP_VH: vh_q <= (m2n_q[63:48] != 16'd0) ? {64{1'b1}} : dn_q;
				OP_RT: root_q <= (vh_q[63:48] != 16'd0) ? sr_q << 8 : sr_q;
				OP_NUM: num_q <= rfull;
				OP_Q: wn_q <= clamp_w(add_sat64(w_q, smake64(!m1n_q[63],
					(den == 64'd0) ? ((num_q != 64'd0) ? {64{1'b1}} : 64'd0) : dn_q)));
				default: ;
			endcase
		end
		if (cmd.emit) begin
			weight_out <= VALUE_WIDTH'(status.corr_ok ? wn_q : w_q);
			moment_one_out <= VALUE_WIDTH'(m1n_q);
			moment_two_out <= VALUE_WIDTH'(m2n_q);
		end
	end
endmodule

// ===== design/adam_optimizer_update.sv =====
// Adam parameter update with optional L2 weight decay.
// in_ch carries one parameter element per request: weight, gradient, both
// stored moments and first_of_step, which advances the bias-correction powers
// before that element is used. out_ch returns the new weight and moments.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce this.
// One element is processed at a time over a shared 64x16 multiplier, a
// restoring divider and a bit-serial square root, each op with an issue and
// a writeback step. first_of_step adds the power updates and a nonzero decay
// rate adds the decay op; while either power is still 1.0 the divide, root
// and numerator ops are skipped and the weight passes through unchanged.
// The result is held in an output register; the block takes the next request
// while it waits, and holds the following result until the receiver is ready.
// Reset restores register defaults and sets both powers to 1.0.
module adam_optimizer_update #(
	parameter int VALUE_WIDTH = adam_pkg::VALUE_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	adam_in_if.sink in_ch,
	adam_out_if.source out_ch,
	input logic cfg_we,
	input logic [adam_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [adam_pkg::CFG_DATA_W-1:0] cfg_data
);
	import adam_pkg::*;

	cmd_t cmd;
	status_t status;

	adam_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.status(status),
		.cmd(cmd)
	);

	adam_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.weight_in(in_ch.weight_in),
		.grad_in(in_ch.grad_in),
		.moment_one_in(in_ch.moment_one_in),
		.moment_two_in(in_ch.moment_two_in),
		.first_of_step(in_ch.first_of_step),
		.weight_out(out_ch.weight_out),
		.moment_one_out(out_ch.moment_one_out),
		.moment_two_out(out_ch.moment_two_out)
	);
endmodule
